// ===== hdl/bfm_pkg.sv =====
// Package with shared types, codes and constants of the buffer frame manager.
`timescale 1ns / 1ps
package bfm_pkg;

  localparam int FRAMES_DEF = 16;
  localparam int FIDX_W     = 4;
  localparam int PIN_MAX    = 255;

  typedef enum logic [2:0] {
    OP_READ    = 3'd0,
    OP_UNPIN   = 3'd1,
    OP_ALLOC   = 3'd2,
    OP_DISPOSE = 3'd3,
    OP_FLUSH   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FILLED    = 3'd1,
    ST_NO_FREE   = 3'd2,
    ST_NOT_PIN   = 3'd3,
    ST_NOT_RES   = 3'd4,
    ST_PINNED    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    DC_NONE   = 2'd0,
    DC_WRBACK = 2'd1,
    DC_LOAD   = 2'd2,
    DC_DELETE = 2'd3
  } dcmd_t;

  // One frame entry as stored in the frame memory.
  typedef struct packed {
    logic        valid;
    logic        dirty;
    logic        refd;
    logic [7:0]  pins;
    logic [7:0]  ftag;
    logic [31:0] ptag;
  } frame_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  frame_index;
    logic [1:0]  disk_command;
    logic [7:0]  disk_file;
    logic [31:0] disk_page;
    logic        last;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK_RD,
    S_LOOK_CHK,
    S_HIT_WR,
    S_SWEEP_RD,
    S_SWEEP_CHK,
    S_FILL,
    S_FLUSH_RD,
    S_FLUSH_CHK,
    S_EMIT
  } state_t;

endpackage

// ===== hdl/bfm_if.sv =====
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface bfm_req_if;
  import bfm_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [7:0]  file_id;
  logic [31:0] page_no;
  logic        mark_dirty;
  modport source (output valid, operation, file_id, page_no, mark_dirty, input ready);
  modport sink   (input valid, operation, file_id, page_no, mark_dirty, output ready);
endinterface

interface bfm_res_if;
  import bfm_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  frame_index;
  logic [1:0]  disk_command;
  logic [7:0]  disk_file;
  logic [31:0] disk_page;
  logic        last;
  modport source (output valid, status, frame_index, disk_command, disk_file, disk_page, last,
                  input ready);
  modport sink   (input valid, status, frame_index, disk_command, disk_file, disk_page, last,
                  output ready);
endinterface

// ===== hdl/buffer_frame_manager_clock.sv =====
// Top level of the buffer frame manager with clock replacement.
`timescale 1ns / 1ps
// Buffer pool manager for FRAMES page frames using clock replacement.
// Requests arrive on in_ (operation, file, page, dirty mark); each request
// gives one or more results on out_, the final one flagged by last.
// Disk commands (write back, load, delete) ride on the results.
// The frame table sits in one memory with a registered read. A request is
// taken only when the block is idle; each memory access is a read state,
// then a check state that writes back. A tag lookup walks frames in order.
// A clock sweep makes up to 2*FRAMES hand steps; flush walks the frames in
// order and stops at the first pinned frame of the file. The block is ready
// for the next request in the cycle after the final result is delivered.
// Reset empties every frame at once and sets the hand to FRAMES-1.
// When the receiver stalls, the block holds the result and waits; no
// new request is taken until the last result is delivered.
module buffer_frame_manager_clock
  import bfm_pkg::*;
#(
  parameter int FRAMES = FRAMES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bfm_req_if.sink   in_req,
  bfm_res_if.source out_res
);

  localparam int AW = $clog2(FRAMES);
  localparam int CW = $clog2(FRAMES + 1);

  state_t        state_r, state_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [7:0]    file_r, file_nxt;
  logic [31:0]   page_r, page_nxt;
  logic          dm_r, dm_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] hand_r, hand_nxt;
  logic [CW-1:0] pinned_r, pinned_nxt;
  result_t       res_r, res_nxt;
  state_t        ret_r, ret_nxt;

  logic [AW-1:0] rd_addr;
  frame_t        rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  frame_t        wr_data;

  bfm_frame_mem #(.FRAMES(FRAMES), .AW(AW)) u_mem (
    .clk, .rst_n, .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data
  );

  function automatic result_t mk(input logic [2:0] st, input logic [AW-1:0] fr,
                                 input logic [1:0] dc, input logic [7:0] f,
                                 input logic [31:0] p, input logic l);
    result_t r;
    r.status = st;
    r.frame_index = FIDX_W'(fr);
    r.disk_command = dc;
    r.disk_file = f;
    r.disk_page = p;
    r.last = l;
    return r;
  endfunction

  logic [AW-1:0] hand_inc;
  logic          tag_hit;
  logic          idx_end;
  assign hand_inc = (hand_r == AW'(FRAMES - 1)) ? '0 : hand_r + 1'b1;
  assign tag_hit  = rd_data.valid && rd_data.ftag == file_r && rd_data.ptag == page_r;
  assign idx_end  = idx_r == AW'(FRAMES - 1);

  assign in_req.ready      = state_r == S_IDLE;
  assign out_res.valid     = state_r == S_EMIT;
  assign out_res.status       = res_r.status;
  assign out_res.frame_index  = res_r.frame_index;
  assign out_res.disk_command = res_r.disk_command;
  assign out_res.disk_file    = res_r.disk_file;
  assign out_res.disk_page    = res_r.disk_page;
  assign out_res.last         = res_r.last;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      hand_r   <= AW'(FRAMES - 1);
      ret_r    <= S_IDLE;
    end else begin
      state_r  <= state_nxt;
      hand_r   <= hand_nxt;
      ret_r    <= ret_nxt;
    end
  end

  // Request and result holding registers.
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    file_r   <= file_nxt;
    page_r   <= page_nxt;
    dm_r     <= dm_nxt;
    idx_r    <= idx_nxt;
    pinned_r <= pinned_nxt;
    res_r    <= res_nxt;
  end

  // Sequencer: next state, memory accesses and results.
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    file_nxt   = file_r;
    page_nxt   = page_r;
    dm_nxt     = dm_r;
    idx_nxt    = idx_r;
    hand_nxt   = hand_r;
    pinned_nxt = pinned_r;
    res_nxt    = res_r;
    ret_nxt    = ret_r;
    rd_addr    = idx_r;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_data    = rd_data;
    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          op_nxt     = in_req.operation;
          file_nxt   = in_req.file_id;
          page_nxt   = in_req.page_no;
          dm_nxt     = in_req.mark_dirty;
          idx_nxt    = '0;
          pinned_nxt = '0;
          unique case (op_t'(in_req.operation)) inside
            OP_READ, OP_UNPIN, OP_DISPOSE: state_nxt = S_LOOK_RD;
            OP_ALLOC:  state_nxt = S_SWEEP_RD;
            OP_FLUSH:  state_nxt = S_FLUSH_RD;
            default: begin
              res_nxt   = mk(ST_OK, '0, DC_NONE, '0, '0, 1'b1);
              ret_nxt   = S_IDLE;
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_LOOK_RD: begin
        rd_addr   = idx_r;
        state_nxt = S_LOOK_CHK;
      end
      S_LOOK_CHK: begin
        if (tag_hit) begin
          state_nxt = S_EMIT;
          ret_nxt   = S_IDLE;
          wr_en     = 1'b1;
          unique case (op_t'(op_r))
            OP_READ: begin
              wr_data.refd = 1'b1;
              if (rd_data.pins != 8'(PIN_MAX)) wr_data.pins = rd_data.pins + 1'b1;
              res_nxt = mk(ST_OK, idx_r, DC_NONE, '0, '0, 1'b1);
            end
            OP_UNPIN: begin
              if (rd_data.pins == '0) begin
                wr_en   = 1'b0;
                res_nxt = mk(ST_NOT_PIN, idx_r, DC_NONE, '0, '0, 1'b1);
              end else begin
                wr_data.pins = rd_data.pins - 1'b1;
                if (dm_r) wr_data.dirty = 1'b1;
                res_nxt = mk(ST_OK, idx_r, DC_NONE, '0, '0, 1'b1);
              end
            end
            default: begin
              wr_data.valid = 1'b0;
              wr_data.dirty = 1'b0;
              wr_data.refd  = 1'b0;
              wr_data.pins  = '0;
              res_nxt = mk(ST_OK, idx_r, DC_DELETE, file_r, page_r, 1'b1);
            end
          endcase
        end else if (!idx_end) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_LOOK_RD;
        end else begin
          unique case (op_t'(op_r))
            OP_READ: state_nxt = S_SWEEP_RD;
            OP_UNPIN: begin
              res_nxt   = mk(ST_NOT_RES, '0, DC_NONE, '0, '0, 1'b1);
              ret_nxt   = S_IDLE;
              state_nxt = S_EMIT;
            end
            default: begin
              res_nxt   = mk(ST_OK, '0, DC_DELETE, file_r, page_r, 1'b1);
              ret_nxt   = S_IDLE;
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_SWEEP_RD: begin
        hand_nxt  = hand_inc;
        rd_addr   = hand_inc;
        state_nxt = S_SWEEP_CHK;
      end
      S_SWEEP_CHK: begin
        wr_addr = hand_r;
        if (!rd_data.valid) begin
          state_nxt = S_FILL;
        end else if (rd_data.refd) begin
          wr_en        = 1'b1;
          wr_data.refd = 1'b0;
          state_nxt    = S_SWEEP_RD;
        end else if (rd_data.pins != '0) begin
          pinned_nxt = pinned_r + 1'b1;
          if (pinned_r + 1'b1 >= CW'(FRAMES)) begin
            res_nxt   = mk(ST_NO_FREE, '0, DC_NONE, '0, '0, 1'b1);
            ret_nxt   = S_IDLE;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_SWEEP_RD;
          end
        end else if (rd_data.dirty) begin
          res_nxt   = mk(ST_OK, hand_r, DC_WRBACK, rd_data.ftag, rd_data.ptag, 1'b0);
          ret_nxt   = S_FILL;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        wr_en         = 1'b1;
        wr_addr       = hand_r;
        wr_data.valid = 1'b1;
        wr_data.dirty = 1'b0;
        wr_data.refd  = 1'b1;
        wr_data.pins  = 8'd1;
        wr_data.ftag  = file_r;
        wr_data.ptag  = page_r;
        if (op_r == OP_READ) begin
          res_nxt = mk(ST_FILLED, hand_r, DC_LOAD, file_r, page_r, 1'b1);
        end else begin
          res_nxt = mk(ST_FILLED, hand_r, DC_NONE, '0, '0, 1'b1);
        end
        ret_nxt   = S_IDLE;
        state_nxt = S_EMIT;
      end
      S_FLUSH_RD: begin
        rd_addr   = idx_r;
        state_nxt = S_FLUSH_CHK;
      end
      S_FLUSH_CHK: begin
        if (rd_data.valid && rd_data.ftag == file_r && rd_data.pins != '0) begin
          res_nxt   = mk(ST_PINNED, idx_r, DC_NONE, '0, '0, 1'b1);
          ret_nxt   = S_IDLE;
          state_nxt = S_EMIT;
        end else begin
          if (rd_data.valid && rd_data.ftag == file_r) begin
            wr_en         = 1'b1;
            wr_data.valid = 1'b0;
            wr_data.dirty = 1'b0;
            wr_data.refd  = 1'b0;
            wr_data.pins  = '0;
          end
          idx_nxt = idx_r + 1'b1;
          if (rd_data.valid && rd_data.ftag == file_r && rd_data.dirty) begin
            res_nxt   = mk(ST_OK, idx_r, DC_WRBACK, rd_data.ftag, rd_data.ptag, 1'b0);
            state_nxt = S_EMIT;
            ret_nxt   = idx_end ? S_EMIT : S_FLUSH_RD;
          end else if (idx_end) begin
            res_nxt   = mk(ST_OK, '0, DC_NONE, '0, '0, 1'b1);
            ret_nxt   = S_IDLE;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_FLUSH_RD;
          end
        end
      end
      S_EMIT: begin
        if (out_res.ready) begin
          if (ret_r == S_EMIT) begin
            res_nxt = mk(ST_OK, '0, DC_NONE, '0, '0, 1'b1);
            ret_nxt = S_IDLE;
          end else begin
            state_nxt = ret_r;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // A result is only offered while no request can be taken.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_req.ready && out_res.valid)) else $error("ready and result overlap");
  // A final result always returns to idle once taken.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.ready && out_res.last |=> in_req.ready)
    else $error("no idle after last result");
  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.ready |=> $stable(res_r))
    else $error("result changed while stalled");

endmodule

// ===== hdl/bfm_frame_mem.sv =====
// Frame table memory with registered read and valid bits cleared at reset.
`timescale 1ns / 1ps
module bfm_frame_mem
  import bfm_pkg::*;
#(
  parameter int FRAMES = FRAMES_DEF,
  parameter int AW     = $clog2(FRAMES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [AW-1:0] rd_addr,
  output frame_t        rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  frame_t        wr_data
);

  frame_t            mem [FRAMES];
  logic [FRAMES-1:0] vld_r;
  frame_t            rd_q_r;
  logic              rd_vld_r;

  // Memory array, one write and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  // Per-entry valid bits so unwritten entries read as the reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr] && !(wr_en && wr_addr == rd_addr && 1'b0);
    end
  end

  // Invalid entries read back as an empty frame.
  always_comb begin
    rd_data = rd_q_r;
    if (!rd_vld_r) begin
      rd_data.valid = 1'b0;
      rd_data.dirty = 1'b0;
      rd_data.refd  = 1'b0;
      rd_data.pins  = '0;
    end
  end

endmodule
